[sv/multi_timer_bank_with_watchdog_tick_unit_assert.svh]
// Assertion macros for the timer bank. Clocked on i_clk, masked while i_rst_n is low.
`ifndef MULTI_TIMER_BANK_WITH_WATCHDOG_TICK_UNIT_ASSERT_SVH
`define MULTI_TIMER_BANK_WITH_WATCHDOG_TICK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define MTB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define MTB_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`else

`define MTB_ASSERT(lbl, prop, msg)

`define MTB_NEVER(lbl, expr, msg)

`endif

`endif

[sv/mtb_pkg.sv]
`default_nettype none

package mtb_pkg;

    localparam int TIMERS     = 16;
    localparam int ADDR_W     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W      = $clog2(TIMERS + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [30:0] RUNTIME_WRAP = 31'h7FFF_FFFF;
    localparam logic [15:0] KICK_RESET   = 16'd1000;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_START_ONE  = 3'd1;
    localparam logic [2:0] OP_START_AUTO = 3'd2;
    localparam logic [2:0] OP_STOP       = 3'd3;
    localparam logic [2:0] OP_CHECK      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_INT = 1'd1;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  timer_id;
        logic [31:0] period;
    } t_in;

    typedef struct packed {
        logic        expired;
        logic        watchdog_kick;
        logic        id_error;
        logic [30:0] runtime;
    } t_out;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] reload;
        logic        flag;
        logic        auto_mode;
    } t_entry;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_CMD_RD,
        ST_CMD_WR,
        ST_DONE
    } t_state;

    function automatic t_entry tick_update(input t_entry e);
        t_entry      r;
        logic [31:0] dec;
        r   = e;
        dec = e.count - 32'd1;
        if (e.count != 32'd0) begin
            r.count = dec;
            if (dec == 32'd0) begin
                r.flag = 1'b1;
                if (e.auto_mode) begin
                    r.count = e.reload;
                end
            end
        end
        return r;
    endfunction

    function automatic t_entry cmd_update(input logic [2:0] op, input logic [31:0] period,
                                          input t_entry e);
        t_entry r;
        r = e;
        case (op)
            OP_START_ONE, OP_START_AUTO: begin
                r.count     = period;
                r.reload    = period;
                r.flag      = 1'b0;
                r.auto_mode = (op == OP_START_AUTO);
            end
            OP_STOP: begin
                r.count     = 32'd0;
                r.flag      = 1'b0;
                r.auto_mode = 1'b0;
            end
            OP_CHECK: begin
                r.flag = 1'b0;
            end
            default: begin
                r = e;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/multi_timer_bank_with_watchdog_tick_unit.sv]
// Bank of TIMERS software down-counters with a run-time counter and a watchdog kick
// divider. Every request gives exactly one result. An enabled tick sweeps all timers
// through one read-modify-write path on the single timer memory, one entry per cycle.
// Start, stop and check read the entry, write it back and then give the result; a
// disabled tick, a bad timer id or an unused op goes straight to the result. The result
// register lets a new request in while the previous result is still waiting to be
// taken. No clearing pass is needed after reset.
`default_nettype none

`include "multi_timer_bank_with_watchdog_tick_unit_assert.svh"

module multi_timer_bank_with_watchdog_tick_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire mtb_pkg::t_in                    i_data,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output mtb_pkg::t_out                        o_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [mtb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mtb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mtb_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_sweep;
    logic               r_rd_pend;
    logic [ADDR_W-1:0]  r_rd_addr;
    logic               r_tick_dis;
    logic [15:0]        r_kick_int;
    logic [30:0]        r_run;
    logic [15:0]        r_kick_div;
    t_in                r_item;
    t_out               r_res;
    logic               r_out_vld;
    t_out               r_out;

    t_mem_req           mem_req;
    t_entry             rd_data;
    logic               in_acc;
    logic               out_free;
    logic               out_load;
    logic               bad_id;
    logic               is_cmd;
    logic               tick_en;
    logic [30:0]        run_inc;
    logic [30:0]        n_run;
    logic [15:0]        n_div;
    logic               kick;

    mtb_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_vld || i_ready;
    assign bad_id   = {1'b0, i_data.timer_id} >= 9'(TIMERS);
    assign is_cmd   = (i_data.op == OP_START_ONE) || (i_data.op == OP_START_AUTO)
                   || (i_data.op == OP_STOP) || (i_data.op == OP_CHECK);
    assign tick_en  = (i_data.op == OP_TICK) && !r_tick_dis;

    // run-time counter skips the all-ones value
    assign run_inc = r_run + 31'd1;
    assign n_run   = (run_inc == RUNTIME_WRAP) ? '0 : run_inc;
    assign n_div   = r_kick_div + 16'd1;
    assign kick    = n_div >= r_kick_int;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (tick_en) begin
                        n_state = ST_SWEEP;
                    end else if (is_cmd && !bad_id) begin
                        n_state = ST_CMD_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SWEEP: begin
                if (r_sweep == CNT_W'(TIMERS)) begin
                    n_state = ST_DONE;
                end
            end
            ST_CMD_RD: n_state = ST_CMD_WR;
            ST_CMD_WR: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sweep is a two-deep pipe: read entry k while writing back entry k-1,
    // so no entry is read and written in overlapping cycles.
    always_comb begin
        mem_req  = '0;
        out_load = 1'b0;
        o_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_SWEEP: begin
                if (r_sweep != CNT_W'(TIMERS)) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_sweep[ADDR_W-1:0];
                end
                if (r_rd_pend) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_rd_addr;
                    mem_req.wr_data = tick_update(rd_data);
                end
            end
            ST_CMD_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_item.timer_id[ADDR_W-1:0];
            end
            ST_CMD_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_item.timer_id[ADDR_W-1:0];
                mem_req.wr_data = cmd_update(r_item.op, r_item.period, rd_data);
            end
            ST_DONE: out_load = out_free;
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_sweep    <= '0;
            r_rd_pend  <= 1'b0;
            r_tick_dis <= 1'b0;
            r_kick_int <= KICK_RESET;
            r_run      <= '0;
            r_kick_div <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= mem_req.rd_en && (r_state == ST_SWEEP);
            if (in_acc) begin
                r_sweep <= '0;
            end else if (mem_req.rd_en && (r_state == ST_SWEEP)) begin
                r_sweep <= r_sweep + CNT_W'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TICK_DIS: r_tick_dis <= i_cfg_data[0];
                    CFG_KICK_INT: r_kick_int <= i_cfg_data;
                    default:      r_tick_dis <= r_tick_dis;
                endcase
            end
            if (in_acc && tick_en) begin
                r_run      <= n_run;
                r_kick_div <= kick ? '0 : n_div;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= mem_req.rd_addr;
        if (in_acc) begin
            r_item                <= i_data;
            r_res.expired         <= 1'b0;
            r_res.watchdog_kick   <= tick_en && kick;
            r_res.id_error        <= is_cmd && bad_id;
            r_res.runtime         <= tick_en ? n_run : r_run;
        end
        if ((r_state == ST_CMD_WR) && (r_item.op == OP_CHECK)) begin
            r_res.expired <= rd_data.flag;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    `MTB_ASSERT(a_wr_phase, mem_req.wr_en |-> (r_state == ST_SWEEP || r_state == ST_CMD_WR), "memory write outside a write phase")
    `MTB_NEVER(a_sweep_bound, r_sweep > CNT_W'(TIMERS), "sweep counter ran past the last timer")
    `MTB_ASSERT(a_tick_sweeps, (in_acc && tick_en) |=> (r_state == ST_SWEEP), "enabled tick did not start a sweep")
    `MTB_ASSERT(a_res_wait, (r_state == ST_DONE && r_out_vld && !i_ready) |=> (r_state == ST_DONE && r_out_vld), "result overwrote a waiting one")

endmodule

`default_nettype wire

[sv/mtb_store.sv]
`default_nettype none

// Timer state memory: one entry per timer, registered read.
// Entries never written since reset read as all zero via per-entry valid bits.
module mtb_store (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mtb_pkg::t_mem_req i_req,
    output mtb_pkg::t_entry       o_rd_data
);
    import mtb_pkg::*;

    t_entry              mem [TIMERS];
    logic   [TIMERS-1:0] r_valid;
    t_entry              r_rd_q;
    logic                r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_q <= mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_q : '0;

endmodule

`default_nettype wire

[test/multi_timer_bank_with_watchdog_tick_unit_tb.sv]
module multi_timer_bank_with_watchdog_tick_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtb_pkg::*;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    localparam int SETTLE_CYCLES    = 2 * (TIMERS + 3);
    localparam int LONG_HOLD_AT     = 500;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int PHASES           = 8;
    localparam int PHASE_REQS       = 134;

    // 65535 followed by 5 drops the interval below a well advanced divider
    localparam logic        PHASE_OFF   [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0,
                                                     1'b0, 1'b0, 1'b0, 1'b0};
    localparam logic [15:0] PHASE_EVERY [PHASES] = '{16'd1, 16'd7, 16'd7, 16'd65535,
                                                     16'd5, 16'd0, 16'd2, 16'd1000};

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in                   in_data  = '0;
    logic                  res_valid;
    logic                  out_ready = 1'b0;
    t_out                  res_data;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state and its copy of the registers
    logic [31:0] tmr_left   [TIMERS];
    logic [31:0] tmr_reload [TIMERS];
    logic        tmr_flag   [TIMERS];
    logic        tmr_auto   [TIMERS];
    logic [30:0] run_cnt;
    logic [15:0] kick_div;
    logic        cfg_tick_off;
    logic [15:0] cfg_kick_every;

    t_in  pending_reqs [$];
    t_out due_results  [$];

    int   reqs_queued   = 0;
    int   results_taken = 0;
    int   fail_count    = 0;
    int   n_expired     = 0;
    int   n_kicks       = 0;
    int   n_bad_id      = 0;
    int   send_gap      = 0;
    int   rcv_hold      = 0;
    logic send_burst    = 1'b0;
    logic rcv_burst     = 1'b0;

    multi_timer_bank_with_watchdog_tick_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .o_ready    (in_ready),
        .i_data     (in_data),
        .o_valid    (res_valid),
        .i_ready    (out_ready),
        .o_data     (res_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out bank_step(input t_in req);
        t_out              res;
        logic [15:0]       div_next;
        logic [ADDR_W-1:0] slot;
        int                k;
        res  = '0;
        slot = req.timer_id[ADDR_W-1:0];
        if (req.op == OP_TICK) begin
            if (!cfg_tick_off) begin
                for (k = 0; k < TIMERS; k++) begin
                    if (tmr_left[k] != 32'd0) begin
                        tmr_left[k] = tmr_left[k] - 32'd1;
                        if (tmr_left[k] == 32'd0) begin
                            tmr_flag[k] = 1'b1;
                            if (tmr_auto[k]) begin
                                tmr_left[k] = tmr_reload[k];
                            end
                        end
                    end
                end
                run_cnt = run_cnt + 31'd1;
                if (run_cnt == RUNTIME_WRAP) begin
                    run_cnt = '0;
                end
                div_next = kick_div + 16'd1;
                if (div_next >= cfg_kick_every) begin
                    kick_div          = '0;
                    res.watchdog_kick = 1'b1;
                end else begin
                    kick_div = div_next;
                end
            end
        end else if (req.op <= OP_CHECK) begin
            if (req.timer_id >= TIMERS) begin
                res.id_error = 1'b1;
            end else begin
                case (req.op)
                    OP_START_ONE, OP_START_AUTO: begin
                        tmr_left[slot]   = req.period;
                        tmr_reload[slot] = req.period;
                        tmr_flag[slot]   = 1'b0;
                        tmr_auto[slot]   = (req.op == OP_START_AUTO);
                    end
                    OP_STOP: begin
                        tmr_left[slot] = '0;
                        tmr_flag[slot] = 1'b0;
                        tmr_auto[slot] = 1'b0;
                    end
                    default: begin
                        res.expired    = tmr_flag[slot];
                        tmr_flag[slot] = 1'b0;
                    end
                endcase
            end
        end
        res.runtime = run_cnt;
        return res;
    endfunction

    always @(posedge i_clk) begin : request_driver
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready) begin
                due_results.push_back(bank_step(in_data));
            end
            if (!(in_valid && !in_ready)) begin
                if (send_gap != 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_reqs.size() != 0) begin
                    in_data  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= send_burst ? 0 : $urandom_range(0, 3);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        int   hold_next;
        t_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rcv_hold  <= 0;
        end else begin
            hold_next = rcv_hold;
            if (res_valid && out_ready) begin
                results_taken++;
                if (due_results.size() == 0) begin
                    $display("%0t: result with no request outstanding: got %p", $time, res_data);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (res_data.expired !== want.expired ||
                        res_data.watchdog_kick !== want.watchdog_kick ||
                        res_data.id_error !== want.id_error ||
                        res_data.runtime !== want.runtime) begin
                        $display(
                            "%0t: mismatch: expected expired=%0b kick=%0b id_error=%0b runtime=%0d",
                            $time, want.expired, want.watchdog_kick, want.id_error,
                            want.runtime);
                        $display(
                            "%0t:           actual   expired=%0b kick=%0b id_error=%0b runtime=%0d",
                            $time, res_data.expired, res_data.watchdog_kick,
                            res_data.id_error, res_data.runtime);
                        fail_count++;
                    end
                    n_expired += int'(want.expired);
                    n_kicks   += int'(want.watchdog_kick);
                    n_bad_id  += int'(want.id_error);
                end
                if (results_taken % 150 == 0) begin
                    rcv_burst = ~rcv_burst;
                end
                // one long stall so the block backs up and holds off requests
                if (results_taken == LONG_HOLD_AT) begin
                    hold_next = LONG_HOLD_CYCLES;
                end else begin
                    hold_next = rcv_burst ? 0 : $urandom_range(0, 3);
                end
            end
            if (hold_next > 0) begin
                out_ready <= 1'b0;
                rcv_hold  <= hold_next - 1;
            end else begin
                out_ready <= 1'b1;
                rcv_hold  <= 0;
            end
        end
    end

    task automatic push_req(input logic [2:0] op, input logic [7:0] id, input logic [31:0] period);
        t_in req;
        req.op       = op;
        req.timer_id = id;
        req.period   = period;
        pending_reqs.push_back(req);
        reqs_queued++;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        if (idx == CFG_TICK_DIS) begin
            cfg_tick_off = value[0];
        end else begin
            cfg_kick_every = value;
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (results_taken != reqs_queued) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] draw_period();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 32'd0;
        if (pick == 1) return 32'hFFFF_FFFF;
        if (pick < 5) return $urandom;
        return $urandom_range(1, 9);
    endfunction

    // mostly start / ticks / check runs on one timer, the rest loose noise
    task automatic queue_traffic(input int count);
        int          stop_at;
        logic [7:0]  id;
        logic [2:0]  op;
        stop_at = reqs_queued + count;
        while (reqs_queued < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                id = 8'($urandom_range(0, TIMERS - 1));
                push_req($urandom_range(0, 1) ? OP_START_AUTO : OP_START_ONE, id, draw_period());
                repeat ($urandom_range(0, 12)) push_req(OP_TICK, 8'($urandom), $urandom);
                push_req(OP_CHECK, id, $urandom);
                if ($urandom_range(0, 3) == 0) begin
                    push_req(OP_STOP, id, $urandom);
                end
            end else begin
                op = 3'($urandom_range(0, 7));
                id = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(0, TIMERS - 1));
                push_req(op, id, $urandom);
            end
        end
    endtask

    initial begin : run_sequence
        int p;
        for (p = 0; p < TIMERS; p++) begin
            tmr_left[p]   = '0;
            tmr_reload[p] = '0;
            tmr_flag[p]   = 1'b0;
            tmr_auto[p]   = 1'b0;
        end
        run_cnt        = '0;
        kick_div       = '0;
        cfg_tick_off   = 1'b0;
        cfg_kick_every = KICK_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(CFG_TICK_DIS, 16'd0);
        write_cfg(CFG_KICK_INT, 16'd3);

        push_req(OP_START_ONE,  8'd0,  32'd2);
        push_req(OP_START_AUTO, 8'd1,  32'd3);
        push_req(OP_START_ONE,  8'd2,  32'd0);
        push_req(OP_START_AUTO, 8'd15, 32'hFFFF_FFFF);
        push_req(OP_START_ONE,  8'd3,  32'd1);
        repeat (3) push_req(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
        push_req(OP_CHECK, 8'd0,  32'd0);
        push_req(OP_CHECK, 8'd0,  32'd0);
        push_req(OP_CHECK, 8'd1,  32'd0);
        push_req(OP_CHECK, 8'd2,  32'd0);
        push_req(OP_CHECK, 8'd3,  32'd0);
        push_req(OP_STOP,  8'd1,  32'hA5A5_5A5A);
        push_req(OP_CHECK, 8'd1,  32'd0);
        repeat (3) push_req(OP_TICK, 8'd0, 32'd0);
        push_req(OP_CHECK, 8'd1,  32'd0);
        push_req(OP_START_ONE,  8'd16,  32'd5);
        push_req(OP_CHECK,      8'd255, 32'd0);
        push_req(OP_STOP,       8'd128, 32'd0);
        push_req(OP_START_AUTO, 8'd200, 32'hFFFF_FFFF);
        for (p = int'(OP_UNUSED_FIRST); p <= int'(OP_UNUSED_LAST); p++) begin
            push_req(3'(p), 8'd0, $urandom);
        end

        for (p = 0; p < PHASES; p++) begin
            // sender holds back until every result is in before the registers move
            wait_drained();
            write_cfg(CFG_TICK_DIS, {15'($urandom), PHASE_OFF[p]});
            write_cfg(CFG_KICK_INT, PHASE_EVERY[p]);
            send_burst = p[0];
            queue_traffic(PHASE_REQS);
        end
        wait_drained();

        if (due_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, due_results.size());
            fail_count++;
        end
        $display("Ran %0d requests over %0d register settings, with idle gaps and stalls",
                 reqs_queued, PHASES + 1);
        $display("on both sides: %0d expiries read back, %0d watchdog kicks, %0d bad timer ids.",
                 n_expired, n_kicks, n_bad_id);
        if (fail_count == 0) begin
            $display("multi_timer_bank_with_watchdog_tick_unit verification clean");
        end else begin
            $display("multi_timer_bank_with_watchdog_tick_unit verification failed");
        end
        $finish;
    end

    initial begin : watchdog_limit
        #5_000_000;
        $display("%0t: run did not complete", $time);
        $display("multi_timer_bank_with_watchdog_tick_unit verification failed");
        $finish;
    end

endmodule
